>>> src/assert_macros.svh
// Assertion macros used by the zero-crossing counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset or not.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the active-low reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> src/zcc_pkg.sv
// Types and constants of the dual-channel zero-crossing counter.
`default_nettype none

package zcc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 8;
    localparam int WINDOW_W = 8;
    localparam int THRESH_W = 16;
    localparam int CFG_W    = 16;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } t_cfg_idx;

    // Sign state of one channel.
    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd3
    } t_sign;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_b;
        logic signed [SAMPLE_W-1:0] sample_a;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_a;
    } t_out_word;

    // Per-word control broadcast to every lane.
    typedef struct packed {
        logic en;
        logic last;
    } t_lane_ctl;

endpackage

`default_nettype wire

>>> src/zcc_lane.sv
// One channel lane: sample classification, sign tracking and crossing count.
`default_nettype none

module zcc_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire zcc_pkg::t_lane_ctl                 i_ctl,
    input  wire logic signed [zcc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [zcc_pkg::THRESH_W-1:0]        i_threshold,
    output logic [zcc_pkg::COUNT_W-1:0]              o_count
);
    import zcc_pkg::*;

    t_sign              r_sign, n_sign;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SAMPLE_W:0]  mag;
    logic               neg;
    t_sign              cls;

    // Magnitude is one bit wider so that the most negative sample stays exact.
    always_comb begin
        neg = i_sample[SAMPLE_W-1];
        if (neg) begin
            mag = (SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, i_sample};
        end else begin
            mag = {1'b0, i_sample};
        end
        if (mag < {1'b0, i_threshold} || mag == '0) begin
            cls = SIGN_NONE;
        end else if (neg) begin
            cls = SIGN_NEG;
        end else begin
            cls = SIGN_POS;
        end
    end

    always_comb begin
        n_sign  = r_sign;
        n_count = r_count;
        if (cls != SIGN_NONE) begin
            if (r_sign == SIGN_NONE) begin
                n_sign = cls;
            end else if (r_sign != cls) begin
                n_sign  = cls;
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    // The count including the current word feeds the result register.
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign  <= SIGN_NONE;
            r_count <= '0;
        end else if (i_ctl.en) begin
            if (i_ctl.last) begin
                r_sign  <= SIGN_NONE;
                r_count <= '0;
            end else begin
                r_sign  <= n_sign;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/zcc_merge.sv
// Merge stage: joins the lane counts into one result word and holds it.
`default_nettype none

module zcc_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [zcc_pkg::COUNT_W-1:0]   i_count_a,
    input  wire logic [zcc_pkg::COUNT_W-1:0]   i_count_b,
    input  wire logic                          i_stall,
    output logic                               o_busy,
    output logic                               o_valid,
    output zcc_pkg::t_out_word                 o_data
);
    import zcc_pkg::*;

    logic      r_valid;
    t_out_word r_data;

    // A held word blocks new results only while the far side stalls.
    assign o_busy  = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.count_a <= i_count_a;
            r_data.count_b <= i_count_b;
        end
    end

endmodule

`default_nettype wire

>>> src/dual_channel_zero_crossing_counter.sv
// Top level of the dual-channel windowed zero-crossing counter.
//
//   channel  direction  word        handshake
//   input    in         t_in_word   i_valid / o_stall
//   output   out        t_out_word  o_valid / i_stall
//   config   in         16 bits     i_cfg_wr_en, i_cfg_addr
//
// One word per unstalled cycle; each lane compares and updates its sign in that cycle.
// The result of a window sits in the merge register in the cycle after its last word.
// While the window size is zero the input is stalled. After reset all counts, signs
// and the pair counter are clear and the window size is zero.
// Otherwise the input stalls only when a finished result is held and the output side stalls.
`default_nettype none
`include "assert_macros.svh"

module dual_channel_zero_crossing_counter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire zcc_pkg::t_in_word            i_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output zcc_pkg::t_out_word                o_data,
    input  wire logic                         i_cfg_wr_en,
    input  wire zcc_pkg::t_cfg_idx            i_cfg_addr,
    input  wire logic [zcc_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import zcc_pkg::*;

    logic [WINDOW_W-1:0] r_window;
    logic [THRESH_W-1:0] r_threshold;
    logic [WINDOW_W-1:0] r_pairs, n_pairs;
    logic                accept;
    logic                merge_busy;
    t_lane_ctl           ctl;
    logic [COUNT_W-1:0]  count_a, count_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_threshold <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_SIZE: r_window    <= i_cfg_wdata[WINDOW_W-1:0];
                CFG_THRESHOLD:   r_threshold <= i_cfg_wdata[THRESH_W-1:0];
                default:         ;
            endcase
        end
    end

    assign o_stall  = (r_window == '0) | merge_busy;
    assign accept   = i_valid & ~o_stall;
    assign n_pairs  = r_pairs + WINDOW_W'(1);
    assign ctl.en   = accept;
    assign ctl.last = (n_pairs >= r_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= '0;
        end else if (accept) begin
            r_pairs <= ctl.last ? '0 : n_pairs;
        end
    end

    zcc_lane u_lane_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_data.sample_a),
        .i_threshold (r_threshold),
        .o_count     (count_a)
    );

    zcc_lane u_lane_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_data.sample_b),
        .i_threshold (r_threshold),
        .o_count     (count_b)
    );

    zcc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept & ctl.last),
        .i_count_a (count_a),
        .i_count_b (count_b),
        .i_stall   (i_stall),
        .o_busy    (merge_busy),
        .o_valid   (o_valid),
        .o_data    (o_data)
    );

    `ASSERT_RUN(a_result_after_word, i_clk, i_rst_n, $rose(o_valid) |-> $past(accept), "result without a closing word")
    `ASSERT_RUN(a_window_restart, i_clk, i_rst_n, (accept && ctl.last) |=> (r_pairs == '0), "pair counter not cleared at window end")
    `ASSERT_RUN(a_pair_step, i_clk, i_rst_n, (accept && !ctl.last) |=> (r_pairs == $past(n_pairs)), "pair counter skipped a word")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the dual-channel windowed zero-crossing counter.
`default_nettype none

module tb_top;
    import zcc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_WORDS = 1000;

    // Tracks the window state of both channels and keeps the counts still owed.
    class zc_scoreboard;
        logic [WINDOW_W-1:0] window_size;
        logic [THRESH_W-1:0] threshold;
        t_sign               sign_st[2];
        logic [COUNT_W-1:0]  crossings[2];
        logic [WINDOW_W-1:0] pairs_seen;
        t_out_word           counts_q[$];
        int                  fails;

        function new();
            window_size = '0;
            threshold   = '0;
            fails       = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int c = 0; c < 2; c++) begin
                sign_st[c]   = SIGN_NONE;
                crossings[c] = '0;
            end
            pairs_seen = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_WINDOW_SIZE: window_size = val[WINDOW_W-1:0];
                CFG_THRESHOLD:   threshold   = val[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // The magnitude is one bit wider so that the most negative sample stays 32768.
        function t_sign sample_sign(logic [SAMPLE_W-1:0] s);
            logic [SAMPLE_W:0] mag;
            mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
            if (mag < {1'b0, threshold} || mag == '0)
                return SIGN_NONE;
            return s[SAMPLE_W-1] ? SIGN_NEG : SIGN_POS;
        endfunction

        function void note_pair(t_in_word w);
            logic [SAMPLE_W-1:0] samp[2];
            t_sign               cls;
            t_out_word           res;
            if (window_size == '0)
                return;
            samp[0] = w.sample_a;
            samp[1] = w.sample_b;
            for (int c = 0; c < 2; c++) begin
                cls = sample_sign(samp[c]);
                if (cls != SIGN_NONE) begin
                    if (sign_st[c] == SIGN_NONE) begin
                        sign_st[c] = cls;
                    end else if (sign_st[c] != cls) begin
                        crossings[c] = crossings[c] + COUNT_W'(1);
                        sign_st[c]   = cls;
                    end
                end
            end
            pairs_seen = pairs_seen + WINDOW_W'(1);
            if (pairs_seen >= window_size) begin
                res.count_a = crossings[0];
                res.count_b = crossings[1];
                counts_q.push_back(res);
                clear_window();
            end
        endfunction

        function void check_counts(t_out_word got);
            t_out_word want;
            if (counts_q.size() == 0) begin
                $display("%0t: unexpected word, count_a=%0d count_b=%0d",
                         $time, got.count_a, got.count_b);
                fails++;
                return;
            end
            want = counts_q.pop_front();
            if (got.count_a !== want.count_a) begin
                $display("%0t: count_a mismatch, expected %0d, got %0d",
                         $time, want.count_a, got.count_a);
                fails++;
            end
            if (got.count_b !== want.count_b) begin
                $display("%0t: count_b mismatch, expected %0d, got %0d",
                         $time, want.count_b, got.count_b);
                fails++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in_word         i_data = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out_word        o_data;
    logic             i_cfg_wr_en = 1'b0;
    t_cfg_idx         i_cfg_addr = CFG_WINDOW_SIZE;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    zc_scoreboard sb;
    bit           tx_gaps = 1'b0;
    bit           rx_gaps = 1'b0;
    bit           hold_req = 1'b0;
    int           cycle_cnt = 0;

    dual_channel_zero_crossing_counter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Values sampled right after the edge are the ones the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pair(i_data);
            if (o_valid && !i_stall)
                sb.check_counts(o_data);
            if (i_cfg_wr_en)
                sb.write_reg(i_cfg_addr, i_cfg_wdata);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end else begin
                i_stall <= rx_gaps && ($urandom_range(99) < 16);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
        t_in_word w;
        w.sample_a = a;
        w.sample_b = b;
        while (tx_gaps && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_data  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every owed word is out and a partly filled window has settled.
    // The first edge lets the monitor note the last accepted word before the queue is read.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.counts_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly magnitudes close to the threshold with random signs, some noise and extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [THRESH_W-1:0] thr);
        int unsigned r;
        int          m;
        r = $urandom_range(99);
        if (r < 10)
            return SAMPLE_W'($urandom);
        if (r < 16) begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end
        m = int'(thr) + int'($urandom_range(48)) - 16;
        if (m < 0)
            m = 0;
        if (m > 32767)
            m = 32767;
        return $urandom_range(1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    initial begin
        int                  sent;
        int                  n;
        int                  phase;
        logic [WINDOW_W-1:0] win;
        logic [THRESH_W-1:0] thr;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first word waits at the input while the window size is still zero.
        fork
            send_pair(16'h0000, 16'h0000);
            begin
                write_reg(CFG_THRESHOLD, 16'h0000);
                write_reg(CFG_WINDOW_SIZE, 16'd4);
            end
        join
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0001, 16'hFFFF);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0000, 16'h0000);
        drain();

        // Only the most negative sample reaches this threshold.
        write_reg(CFG_THRESHOLD, 16'h8000);
        write_reg(CFG_WINDOW_SIZE, 16'd3);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        drain();

        // Samples just at and just below the threshold, then a shorter window mid-way.
        write_reg(CFG_THRESHOLD, 16'd100);
        write_reg(CFG_WINDOW_SIZE, 16'd5);
        send_pair(16'h0064, 16'hFF9D);
        send_pair(16'hFF9C, 16'h0063);
        drain();
        write_reg(CFG_WINDOW_SIZE, 16'd2);
        send_pair(16'h8000, 16'h0064);
        drain();

        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_WINDOW_SIZE, 16'd1);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            if (phase == 0) begin
                win = 8'd255;
                thr = 16'd0;
                n   = 260;
            end else if (phase == 2) begin
                win = 8'd1;
                thr = THRESH_W'($urandom_range(200));
                n   = 40;
            end else begin
                case ($urandom_range(4))
                    0: win = 8'd1;
                    1: win = 8'd2;
                    2: win = WINDOW_W'($urandom_range(3, 12));
                    3: win = WINDOW_W'($urandom_range(13, 40));
                    default: win = WINDOW_W'($urandom_range(1, 255));
                endcase
                case ($urandom_range(5))
                    0: thr = 16'd0;
                    1: thr = 16'hFFFF;
                    2: thr = 16'h8000;
                    3: thr = 16'h7FFF;
                    4: thr = THRESH_W'($urandom_range(1, 2000));
                    default: thr = THRESH_W'($urandom);
                endcase
                n = $urandom_range(8, 60);
            end
            // The first random phase runs without any idling on either side.
            tx_gaps = (phase != 0);
            rx_gaps = (phase != 0);
            if (phase > 2 && $urandom_range(3) == 0)
                write_reg(CFG_WINDOW_SIZE, {8'($urandom), 8'd0});
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_WINDOW_SIZE, {8'($urandom), win});
            if (phase == 2)
                hold_req = 1'b1;
            repeat (n)
                send_pair(pick_sample(thr), pick_sample(thr));
            sent += n;
            drain();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.counts_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
